>>> hdl/rsi_pkg.sv
package rsi_pkg;

  // Alphabet storage: sixteen byte-wide characters in two 64-bit registers
  localparam int unsigned ALPHA_CHARS = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CHARS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CHARS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH     = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ALPHA = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DIGIT = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // Digit lookup and alphabet check handed to the parser
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] digit_idx;
    logic             alpha_bad;
  } lookup_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

endpackage

>>> hdl/rsi_lookup.sv
module rsi_lookup #(
  parameter int unsigned MAX_BASE_LENGTH = 16
) (
  input  logic [rsi_pkg::ALPHA_CHARS*rsi_pkg::CHAR_W-1:0] alphabet_i,
  input  logic [rsi_pkg::LEN_W-1:0]                       base_length_i,
  input  logic [rsi_pkg::LEN_W-1:0]                       radix_i,
  input  logic [rsi_pkg::CHAR_W-1:0]                      char_i,
  output rsi_pkg::lookup_t                                lookup_o
);

  localparam logic [rsi_pkg::LEN_W-1:0] MAX_LEN = rsi_pkg::LEN_W'(MAX_BASE_LENGTH);
  localparam logic [rsi_pkg::LEN_W-1:0] MIN_LEN = rsi_pkg::LEN_W'(2);

  logic [rsi_pkg::CHAR_W-1:0] chars [MAX_BASE_LENGTH];
  logic                       found;
  logic [rsi_pkg::IDX_W-1:0]  digit_idx;
  logic                       alpha_bad;

  // Split the alphabet into characters
  always_comb begin
    for (int k = 0; k < MAX_BASE_LENGTH; k++) begin
      chars[k] = alphabet_i[k*rsi_pkg::CHAR_W +: rsi_pkg::CHAR_W];
    end
  end

  // Match the character against the active alphabet, lowest index wins
  always_comb begin
    found     = 1'b0;
    digit_idx = '0;
    for (int k = MAX_BASE_LENGTH - 1; k >= 0; k--) begin
      if ((rsi_pkg::LEN_W'(k) < radix_i) && (chars[k] == char_i)) begin
        found     = 1'b1;
        digit_idx = rsi_pkg::IDX_W'(k);
      end
    end
  end

  // Check the alphabet: length range, forbidden characters, repeats
  always_comb begin
    alpha_bad = (base_length_i < MIN_LEN) || (base_length_i > MAX_LEN);
    for (int i = 0; i < MAX_BASE_LENGTH; i++) begin
      if (rsi_pkg::LEN_W'(i) < base_length_i) begin
        if ((chars[i] == rsi_pkg::CHAR_NUL) || rsi_pkg::is_space(chars[i])) begin
          alpha_bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_BASE_LENGTH; j++) begin
          if ((rsi_pkg::LEN_W'(j) < base_length_i) && (chars[j] == chars[i])) begin
            alpha_bad = 1'b1;
          end
        end
      end
    end
  end

  assign lookup_o = '{found: found, digit_idx: digit_idx, alpha_bad: alpha_bad};

endmodule

>>> hdl/rsi_parse.sv
module rsi_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [rsi_pkg::CHAR_W-1:0]    char_i,
  input  logic                          term_i,
  input  logic [rsi_pkg::LEN_W-1:0]     radix_i,
  input  rsi_pkg::lookup_t              lookup_i,
  output logic [rsi_pkg::VALUE_W-1:0]   value_o,
  output logic [rsi_pkg::STATUS_W-1:0]  status_o
);

  logic                         in_digits_q, in_digits_d;
  logic                         negative_q, negative_d;
  logic                         bad_digit_q, bad_digit_d;
  logic [rsi_pkg::VALUE_W-1:0]  acc_q, acc_d;
  logic [rsi_pkg::VALUE_W-1:0]  product;
  logic                         is_prefix;

  assign is_prefix = !in_digits_q &&
                     (rsi_pkg::is_space(char_i) || (char_i == rsi_pkg::CHAR_PLUS) ||
                      (char_i == rsi_pkg::CHAR_MINUS));

  // Horner step: acc * radix + digit, wrapped to 32 bits
  assign product = acc_q * rsi_pkg::VALUE_W'(radix_i);

  // Result seen at a terminator
  always_comb begin
    value_o  = '0;
    status_o = rsi_pkg::STATUS_OK;
    if (lookup_i.alpha_bad) begin
      status_o = rsi_pkg::STATUS_BAD_ALPHA;
    end else if (bad_digit_q) begin
      status_o = rsi_pkg::STATUS_BAD_DIGIT;
    end else begin
      value_o = negative_q ? (rsi_pkg::VALUE_W'(0) - acc_q) : acc_q;
    end
  end

  // Advance the parse state for one transaction
  always_comb begin
    in_digits_d = in_digits_q;
    negative_d  = negative_q;
    bad_digit_d = bad_digit_q;
    acc_d       = acc_q;
    if (fire_i) begin
      if (term_i) begin
        in_digits_d = 1'b0;
        negative_d  = 1'b0;
        bad_digit_d = 1'b0;
        acc_d       = '0;
      end else if (is_prefix) begin
        if (char_i == rsi_pkg::CHAR_MINUS) begin
          negative_d = !negative_q;
        end
      end else begin
        in_digits_d = 1'b1;
        if (!lookup_i.found || (char_i == rsi_pkg::CHAR_NUL)) begin
          bad_digit_d = 1'b1;
        end else begin
          acc_d = product + rsi_pkg::VALUE_W'(lookup_i.digit_idx);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_digits_q <= 1'b0;
      negative_q  <= 1'b0;
      bad_digit_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      in_digits_q <= in_digits_d;
      negative_q  <= negative_d;
      bad_digit_q <= bad_digit_d;
      acc_q       <= acc_d;
    end
  end

endmodule

>>> hdl/radix_string_to_integer_top.sv
// Result path: a terminator accepted into the input register loads the result
//   register when it drains from there, which raises out_valid_o.
// Throughput: one character per cycle; a terminator waits in the input
//   register only while an earlier result is still held on the output.
// Reset (rst_ni low, asynchronous): parse state, alphabet registers and
//   both valid flags clear to zero.
module radix_string_to_integer_top #(
  parameter int unsigned MAX_BASE_LENGTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rsi_pkg::CHAR_W-1:0]           char_code_i,
  input  logic                                 terminator_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rsi_pkg::VALUE_W-1:0]   value_o,
  output logic [rsi_pkg::STATUS_W-1:0]         status_o
);

  localparam logic [rsi_pkg::LEN_W-1:0] MAX_LEN = rsi_pkg::LEN_W'(MAX_BASE_LENGTH);

  logic [rsi_pkg::CFG_DATA_W-1:0] chars_low_q, chars_high_q;
  logic [rsi_pkg::LEN_W-1:0]      base_length_q;
  logic [rsi_pkg::LEN_W-1:0]      radix;

  logic                           s1_valid_q;
  logic [rsi_pkg::CHAR_W-1:0]     s1_char_q;
  logic                           s1_term_q;
  logic                           s1_fire;

  logic                           out_valid_q;
  logic [rsi_pkg::VALUE_W-1:0]    value_q;
  logic [rsi_pkg::STATUS_W-1:0]   status_q;

  rsi_pkg::lookup_t               lookup;
  logic [rsi_pkg::VALUE_W-1:0]    res_value;
  logic [rsi_pkg::STATUS_W-1:0]   res_status;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_low_q   <= '0;
      chars_high_q  <= '0;
      base_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rsi_pkg::CFG_BASE_CHARS_LOW:  chars_low_q   <= cfg_wdata_i;
        rsi_pkg::CFG_BASE_CHARS_HIGH: chars_high_q  <= cfg_wdata_i;
        rsi_pkg::CFG_BASE_LENGTH:     base_length_q <= cfg_wdata_i[rsi_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the radix to the supported alphabet size
  assign radix = (base_length_q > MAX_LEN) ? MAX_LEN : base_length_q;

  // Input register: drains unless a terminator meets a held result
  assign s1_fire    = s1_valid_q && (!s1_term_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= char_code_i;
      s1_term_q <= terminator_i;
    end
  end

  rsi_lookup #(
    .MAX_BASE_LENGTH (MAX_BASE_LENGTH)
  ) u_lookup (
    .alphabet_i    ({chars_high_q, chars_low_q}),
    .base_length_i (base_length_q),
    .radix_i       (radix),
    .char_i        (s1_char_q),
    .lookup_o      (lookup)
  );

  rsi_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .char_i   (s1_char_q),
    .term_i   (s1_term_q),
    .radix_i  (radix),
    .lookup_i (lookup),
    .value_o  (res_value),
    .status_o (res_status)
  );

  // Result register: load on terminator, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_term_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_term_q) begin
      value_q  <= res_value;
      status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

>>> hdl/rsi_checker.sv
module rsi_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                terminator_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [rsi_pkg::VALUE_W-1:0]  value_o,
  input logic [rsi_pkg::STATUS_W-1:0]        status_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Any error reports a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != rsi_pkg::STATUS_OK) |-> value_o == '0)
    else $error("error result with nonzero value");

  // A fresh result follows a terminator transaction through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && terminator_i, 2))
    else $error("result without a terminator transaction");

  // Input backpressure only while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

endmodule

bind radix_string_to_integer_top rsi_checker u_rsi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .terminator_i (terminator_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .value_o      (value_o),
  .status_o     (status_o)
);
